### rtl/odi_pkg.sv
`timescale 1ns / 1ps
package odi_pkg;

	typedef struct packed {
		logic [19:0]        us;
		logic               present;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] wz;
	} item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_ROT,
		ST_MUL,
		ST_RND,
		ST_PSTART,
		ST_WAIT,
		ST_COMMIT
	} st_t;

	localparam logic       CFG_MIN_GAP = 1'b0;
	localparam logic       CFG_MAX_GAP = 1'b1;
	localparam logic [19:0] MIN_GAP_RST = 20'd1000;
	localparam logic [19:0] MAX_GAP_RST = 20'd200000;

	localparam logic signed [31:0] PI_Q      = 32'sd843314857;
	localparam logic signed [31:0] HALF_PI_Q = 32'sd421657428;
	localparam logic signed [33:0] GAIN_Q30  = 34'sd652032874;
	localparam int                 ATAN_LEN  = 30;

	// position divide: |w*us| + 500000 over 1e6
	localparam int          PD_NW = 54;
	localparam int          PD_QW = 34;
	localparam int          PD_DW = 20;
	localparam logic [19:0] PD_DIV  = 20'd1000000;
	localparam logic [53:0] PD_HALF = 54'd500000;
	// heading divide: |wz*us*64| + 7812 over 15625
	localparam int          HD_NW = 58;
	localparam int          HD_QW = 44;
	localparam int          HD_DW = 14;
	localparam logic [13:0] HD_DIV  = 14'd15625;
	localparam logic [57:0] HD_HALF = 58'd7812;
	// heading wrap: remainder modulo two pi
	localparam int          WD_NW = 45;
	localparam int          WD_QW = 15;
	localparam int          WD_DW = 31;
	localparam logic [30:0] WD_DIV = 31'd1686629714;

	function automatic logic signed [31:0] atan_q28(input logic [4:0] i);
		logic signed [31:0] r;
		case (i)
			5'd0:    r = 32'sd210828714;
			5'd1:    r = 32'sd124459457;
			5'd2:    r = 32'sd65760959;
			5'd3:    r = 32'sd33381290;
			5'd4:    r = 32'sd16755422;
			5'd5:    r = 32'sd8385879;
			5'd6:    r = 32'sd4193963;
			5'd7:    r = 32'sd2097109;
			5'd8:    r = 32'sd1048571;
			5'd9:    r = 32'sd524287;
			5'd10:   r = 32'sd262144;
			5'd11:   r = 32'sd131072;
			5'd12:   r = 32'sd65536;
			5'd13:   r = 32'sd32768;
			5'd14:   r = 32'sd16384;
			5'd15:   r = 32'sd8192;
			5'd16:   r = 32'sd4096;
			5'd17:   r = 32'sd2048;
			5'd18:   r = 32'sd1024;
			5'd19:   r = 32'sd512;
			5'd20:   r = 32'sd256;
			5'd21:   r = 32'sd128;
			5'd22:   r = 32'sd64;
			5'd23:   r = 32'sd32;
			5'd24:   r = 32'sd16;
			5'd25:   r = 32'sd8;
			5'd26:   r = 32'sd4;
			5'd27:   r = 32'sd2;
			5'd28:   r = 32'sd1;
			default: r = 32'sd0;
		endcase
		return r;
	endfunction

endpackage

### rtl/planar_odometry_integrator_unit.sv
`timescale 1ns / 1ps
// channel   signals                                  direction
// request   in_valid/in_ready + 5 fields             in
// result    out_valid/out_ready + 7 fields           out
// config    cfg_we, cfg_addr, cfg_wdata              in
//
// A tick outside the gap window is dropped in the front end with no result.
// A tick with no sample gives its result the cycle after it leaves the queue.
// An updating tick, after leaving the queue, runs the rotation loop, the shared
// rotation multiplier and the reciprocal divide before its result is committed.
// A two-entry queue lets requests land while the back end or result waits.
// Reset clears the pose to zero and loads the gap limits; no clearing pass.
module planar_odometry_integrator_unit #(
	parameter int CORDIC_STEPS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_addr,
	input  logic [19:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [19:0]        elapsed_us,
	input  logic               sample_present,
	input  logic signed [31:0] vel_fwd,
	input  logic signed [31:0] vel_side,
	input  logic signed [31:0] turn_rate,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [30:0] heading,
	output logic signed [31:0] out_vel_fwd,
	output logic signed [31:0] out_vel_side,
	output logic signed [31:0] out_turn_rate,
	output logic               sample_missing
);
	import odi_pkg::*;

	item_t in_item, push_item, pop_item;
	logic  q_ready, q_push, q_valid, q_pop;

	assign in_item.us      = elapsed_us;
	assign in_item.present = sample_present;
	assign in_item.vx      = vel_fwd;
	assign in_item.vy      = vel_side;
	assign in_item.wz      = turn_rate;

	odi_front u_front (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.q_ready(q_ready), .q_push(q_push), .q_item(push_item)
	);

	odi_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(q_push), .push_item(push_item), .ready(q_ready),
		.pop(q_pop), .valid(q_valid), .pop_item(pop_item)
	);

	odi_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_item(pop_item), .q_pop(q_pop),
		.out_valid(out_valid), .out_ready(out_ready),
		.pos_x(pos_x), .pos_y(pos_y), .heading(heading),
		.out_vel_fwd(out_vel_fwd), .out_vel_side(out_vel_side),
		.out_turn_rate(out_turn_rate), .sample_missing(sample_missing)
	);

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> q_ready)
		else $error("queue push while full");

	a_pop_data: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue pop while empty");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
		else $error("result dropped before taken");

	a_missing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && sample_missing) |->
			(out_vel_fwd == 32'sd0 && out_turn_rate == 32'sd0))
		else $error("velocity reported with missing sample");

endmodule

### rtl/odi_front.sv
`timescale 1ns / 1ps
module odi_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_addr,
	input  logic [19:0]       cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  odi_pkg::item_t    in_item,
	input  logic              q_ready,
	output logic              q_push,
	output odi_pkg::item_t    q_item
);
	import odi_pkg::*;

	logic [19:0] min_gap_q;
	logic [19:0] max_gap_q;
	logic        in_range;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_gap_q <= MIN_GAP_RST;
			max_gap_q <= MAX_GAP_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_MIN_GAP: min_gap_q <= cfg_wdata;
				CFG_MAX_GAP: max_gap_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign in_range = (in_item.us > min_gap_q) && (in_item.us <= max_gap_q);
	assign in_ready = q_ready;
	assign q_push   = in_valid && q_ready && in_range;
	assign q_item   = in_item;

endmodule

### rtl/odi_queue.sv
`timescale 1ns / 1ps
module odi_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  odi_pkg::item_t  push_item,
	output logic            ready,
	input  logic            pop,
	output logic            valid,
	output odi_pkg::item_t  pop_item
);
	import odi_pkg::*;

	item_t       mem_q [2];
	logic        wptr_q;
	logic        rptr_q;
	logic [1:0]  cnt_q;

	assign ready    = (cnt_q != 2'd2);
	assign valid    = (cnt_q != 2'd0);
	assign pop_item = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### rtl/odi_div.sv
`timescale 1ns / 1ps
module odi_div #(
	parameter int            NW      = 54,
	parameter int            QW      = 34,
	parameter int            DW      = 20,
	parameter logic [DW-1:0] DIVISOR = 20'd1000000
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	output logic          done,
	output logic [QW-1:0] quo,
	output logic [DW-1:0] rem
);
	// reciprocal estimate over four 32x32 partial products, at most one low;
	// one compare and subtract fixes it; done follows the accumulate, fix and check steps
	localparam logic [63:0] RECIP = 64'((65'd1 << NW) / {{(65 - DW){1'b0}}, DIVISOR});
	localparam int          RW    = DW + 2;

	logic [63:0]   num_q;
	logic [127:0]  acc_q;
	logic [1:0]    step_q;
	logic          busy_q;
	logic          fix_q;
	logic          chk_q;
	logic          done_q;
	logic [QW-1:0] qest_q;
	logic [QW-1:0] quo_q;
	logic [RW-1:0] rest_q;
	logic [DW-1:0] rem_q;
	logic [31:0]   op_a;
	logic [31:0]   op_b;
	logic [63:0]   pp;
	logic [127:0]  pp_sh;
	logic [QW-1:0] qest;
	logic [RW-1:0] qd_lo;

	assign op_a  = step_q[1] ? num_q[63:32] : num_q[31:0];
	assign op_b  = step_q[0] ? RECIP[63:32] : RECIP[31:0];
	assign pp    = op_a * op_b;
	assign pp_sh = {64'b0, pp} << {({1'b0, step_q[1]} + {1'b0, step_q[0]}), 5'b0};
	assign qest  = acc_q[NW +: QW];
	assign qd_lo = RW'(RW'(qest) * RW'(DIVISOR));

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= 64'(dividend);
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + pp_sh;
		end
		if (fix_q) begin
			qest_q <= qest;
			rest_q <= num_q[RW-1:0] - qd_lo;
		end
		if (chk_q) begin
			if (rest_q >= {2'b0, DIVISOR}) begin
				quo_q <= qest_q + QW'(1);
				rem_q <= DW'(rest_q - {2'b0, DIVISOR});
			end else begin
				quo_q <= qest_q;
				rem_q <= rest_q[DW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 2'd0;
			fix_q  <= 1'b0;
			chk_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			fix_q  <= 1'b0;
			chk_q  <= fix_q;
			done_q <= chk_q;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 2'd0;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					busy_q <= 1'b0;
					fix_q  <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

### rtl/odi_back.sv
`timescale 1ns / 1ps
module odi_back #(
	parameter int CORDIC_STEPS = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  odi_pkg::item_t      q_item,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [31:0]  pos_x,
	output logic signed [31:0]  pos_y,
	output logic signed [30:0]  heading,
	output logic signed [31:0]  out_vel_fwd,
	output logic signed [31:0]  out_vel_side,
	output logic signed [31:0]  out_turn_rate,
	output logic                sample_missing
);
	import odi_pkg::*;

	localparam int         NSTEP = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
	localparam logic [4:0] LAST  = 5'(NSTEP - 1);
	localparam logic signed [45:0] PI_W = 46'(PI_Q);

	st_t                st_q, st_d;
	item_t              it_q;
	logic [4:0]         cnt_q;
	logic [2:0]         mcnt_q;
	logic signed [33:0] cx_q, cy_q;
	logic signed [31:0] cz_q;
	logic               flip_q;
	logic signed [52:0] hprod_q;
	logic signed [65:0] prod_q;
	logic signed [66:0] ax_q, ay_q;
	logic signed [54:0] px_q, py_q;
	logic               wrap_pos_q, hready_q;
	logic signed [31:0] hnew_q;
	logic signed [31:0] wx_q, wy_q, wh_q;
	logic               ov_q;

	logic               out_free, load_idle, load_commit;
	logic signed [33:0] xs, ys, cf, sf;
	logic signed [31:0] at;
	logic signed [31:0] mul_a;
	logic signed [33:0] mul_b;
	logic signed [66:0] rx, ry;
	logic signed [33:0] wxr, wyr;
	logic [51:0]        hmag;
	logic [53:0]        xmag, ymag;
	logic               hstart, pstart, mstart;
	logic [57:0]        hdividend;
	logic [53:0]        xdividend, ydividend;
	logic [44:0]        mdividend;
	logic               hdone, xdone, ydone, mdone;
	logic [43:0]        hq;
	logic [33:0]        xq, yq;
	logic [30:0]        mrem;
	logic [13:0]        hrem_unused;
	logic [19:0]        xrem_unused, yrem_unused;
	logic [14:0]        mq_unused;
	logic signed [44:0] dh;
	logic signed [45:0] tsum;
	logic               t_hi, t_lo;
	logic signed [34:0] dx, dy;
	logic signed [35:0] sx, sy;
	logic signed [31:0] nx, ny;

	assign out_free    = !ov_q || out_ready;
	assign q_pop       = (st_q == ST_IDLE) && q_valid && out_free;
	assign load_idle   = q_pop && !q_item.present;
	assign load_commit = (st_q == ST_COMMIT) && hready_q && out_free;

	// cordic step
	assign xs = cx_q >>> cnt_q;
	assign ys = cy_q >>> cnt_q;
	assign at = atan_q28(cnt_q);
	assign cf = flip_q ? -cx_q : cx_q;
	assign sf = flip_q ? -cy_q : cy_q;

	always_comb begin
		case (mcnt_q)
			3'd0:    begin mul_a = it_q.vx; mul_b = cf; end
			3'd1:    begin mul_a = it_q.vy; mul_b = sf; end
			3'd2:    begin mul_a = it_q.vx; mul_b = sf; end
			default: begin mul_a = it_q.vy; mul_b = cf; end
		endcase
	end

	assign rx  = ax_q + 67'sd536870912;
	assign ry  = ay_q + 67'sd536870912;
	assign wxr = rx[63:30];
	assign wyr = ry[63:30];

	// heading chain
	assign hmag      = hprod_q[52] ? 52'(-hprod_q) : hprod_q[51:0];
	assign hdividend = {hmag, 6'b0} + HD_HALF;
	assign hstart    = (st_q == ST_ROT) && (cnt_q == 5'd0);

	assign dh   = hprod_q[52] ? -$signed({1'b0, hq}) : $signed({1'b0, hq});
	assign tsum = 46'(wh_q) + 46'(dh);
	assign t_hi = tsum > PI_W;
	assign t_lo = tsum < -PI_W;
	assign mstart    = hdone && (t_hi || t_lo);
	assign mdividend = t_hi ? 45'(tsum - PI_W - 46'sd1) : 45'(-PI_W - tsum - 46'sd1);

	// position
	assign xmag      = px_q[54] ? 54'(-px_q) : px_q[53:0];
	assign ymag      = py_q[54] ? 54'(-py_q) : py_q[53:0];
	assign xdividend = xmag + PD_HALF;
	assign ydividend = ymag + PD_HALF;
	assign pstart    = (st_q == ST_PSTART);

	assign dx = px_q[54] ? -$signed({1'b0, xq}) : $signed({1'b0, xq});
	assign dy = py_q[54] ? -$signed({1'b0, yq}) : $signed({1'b0, yq});
	assign sx = 36'(wx_q) + 36'(dx);
	assign sy = 36'(wy_q) + 36'(dy);
	assign nx = (sx > 36'sd2147483647) ? 32'sh7fffffff :
		(sx < -36'sd2147483648) ? 32'sh80000000 : sx[31:0];
	assign ny = (sy > 36'sd2147483647) ? 32'sh7fffffff :
		(sy < -36'sd2147483648) ? 32'sh80000000 : sy[31:0];

	odi_div #(.NW(HD_NW), .QW(HD_QW), .DW(HD_DW), .DIVISOR(HD_DIV)) u_hdiv (
		.clk(clk), .arst_n(arst_n), .start(hstart), .dividend(hdividend),
		.done(hdone), .quo(hq), .rem(hrem_unused)
	);

	odi_div #(.NW(WD_NW), .QW(WD_QW), .DW(WD_DW), .DIVISOR(WD_DIV)) u_mdiv (
		.clk(clk), .arst_n(arst_n), .start(mstart), .dividend(mdividend),
		.done(mdone), .quo(mq_unused), .rem(mrem)
	);

	odi_div #(.NW(PD_NW), .QW(PD_QW), .DW(PD_DW), .DIVISOR(PD_DIV)) u_xdiv (
		.clk(clk), .arst_n(arst_n), .start(pstart), .dividend(xdividend),
		.done(xdone), .quo(xq), .rem(xrem_unused)
	);

	odi_div #(.NW(PD_NW), .QW(PD_QW), .DW(PD_DW), .DIVISOR(PD_DIV)) u_ydiv (
		.clk(clk), .arst_n(arst_n), .start(pstart), .dividend(ydividend),
		.done(ydone), .quo(yq), .rem(yrem_unused)
	);

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE:   if (q_pop && q_item.present) st_d = ST_PREP;
			ST_PREP:   st_d = ST_ROT;
			ST_ROT:    if (cnt_q == LAST) st_d = ST_MUL;
			ST_MUL:    if (mcnt_q == 3'd4) st_d = ST_RND;
			ST_RND:    st_d = ST_PSTART;
			ST_PSTART: st_d = ST_WAIT;
			ST_WAIT:   if (xdone && ydone) st_d = ST_COMMIT;
			ST_COMMIT: if (load_commit) st_d = ST_IDLE;
			default:   st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (q_pop) begin
			it_q <= q_item;
		end
		case (st_q)
			ST_PREP: begin
				cx_q    <= GAIN_Q30;
				cy_q    <= '0;
				cnt_q   <= 5'd0;
				mcnt_q  <= 3'd0;
				hprod_q <= 53'($signed(it_q.wz) * $signed({1'b0, it_q.us}));
				if (wh_q > HALF_PI_Q) begin
					cz_q   <= wh_q - PI_Q;
					flip_q <= 1'b1;
				end else if (wh_q < -HALF_PI_Q) begin
					cz_q   <= wh_q + PI_Q;
					flip_q <= 1'b1;
				end else begin
					cz_q   <= wh_q;
					flip_q <= 1'b0;
				end
			end
			ST_ROT: begin
				cnt_q <= cnt_q + 5'd1;
				if (!cz_q[31]) begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					cz_q <= cz_q - at;
				end else begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					cz_q <= cz_q + at;
				end
			end
			ST_MUL: begin
				mcnt_q <= mcnt_q + 3'd1;
				prod_q <= mul_a * mul_b;
				case (mcnt_q)
					3'd1:    ax_q <= 67'(prod_q);
					3'd2:    ax_q <= ax_q - 67'(prod_q);
					3'd3:    ay_q <= 67'(prod_q);
					3'd4:    ay_q <= ay_q + 67'(prod_q);
					default: ;
				endcase
			end
			ST_RND: begin
				px_q <= wxr * $signed({1'b0, it_q.us});
				py_q <= wyr * $signed({1'b0, it_q.us});
			end
			default: ;
		endcase
		if (hdone) begin
			wrap_pos_q <= t_hi;
			if (!(t_hi || t_lo)) begin
				hnew_q <= tsum[31:0];
			end
		end
		if (mdone) begin
			hnew_q <= wrap_pos_q ? ($signed({1'b0, mrem}) + 32'sd1 - PI_Q)
				: (PI_Q - 32'sd1 - $signed({1'b0, mrem}));
		end
	end

	// pose state, heading ready flag, result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wx_q     <= '0;
			wy_q     <= '0;
			wh_q     <= '0;
			hready_q <= 1'b0;
			ov_q     <= 1'b0;
		end else begin
			if (st_q == ST_PREP) begin
				hready_q <= 1'b0;
			end else if ((hdone && !(t_hi || t_lo)) || mdone) begin
				hready_q <= 1'b1;
			end
			if (load_commit) begin
				wx_q <= nx;
				wy_q <= ny;
				wh_q <= hnew_q;
			end
			if (load_idle || load_commit) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_idle) begin
			pos_x          <= wx_q;
			pos_y          <= wy_q;
			heading        <= wh_q[30:0];
			out_vel_fwd    <= '0;
			out_vel_side   <= '0;
			out_turn_rate  <= '0;
			sample_missing <= 1'b1;
		end else if (load_commit) begin
			pos_x          <= nx;
			pos_y          <= ny;
			heading        <= hnew_q[30:0];
			out_vel_fwd    <= it_q.vx;
			out_vel_side   <= it_q.vy;
			out_turn_rate  <= it_q.wz;
			sample_missing <= 1'b0;
		end
	end

	assign out_valid = ov_q;

endmodule

### dv/planar_odometry_integrator_unit_tb.sv
`timescale 1ns / 1ps
module planar_odometry_integrator_unit_tb;
	import odi_pkg::*;

	localparam int  STEPS    = 24;
	localparam longint PIQ   = 843314857;
	localparam longint HPIQ  = 421657428;
	localparam longint TPIQ  = 2 * PIQ;
	localparam longint GAINQ = 652032874;
	localparam int  WD_LIMIT = 20000;
	localparam int  SETTLE   = 200;

	localparam longint ARCTAN [30] = '{
		210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
		4193963, 2097109, 1048571, 524287, 262144, 131072, 65536, 32768,
		16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0
	};

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [30:0] hd;
		logic signed [31:0] vf;
		logic signed [31:0] vs;
		logic signed [31:0] wr;
		logic               miss;
	} pose_t;

	logic clk, arst_n;
	logic cfg_we, cfg_addr;
	logic [19:0] cfg_wdata;
	logic in_valid, in_ready;
	logic [19:0] elapsed_us;
	logic sample_present;
	logic signed [31:0] vel_fwd, vel_side, turn_rate;
	logic out_valid, out_ready;
	logic signed [31:0] pos_x, pos_y, out_vel_fwd, out_vel_side, out_turn_rate;
	logic signed [30:0] heading;
	logic sample_missing;

	planar_odometry_integrator_unit #(.CORDIC_STEPS(STEPS)) DUT (.*);

	item_t  tick_q [$];
	pose_t  pose_q [$];
	item_t  cur;
	longint gap_min, gap_max;
	longint px, py, ph;
	int     errors, sender_gap, stall_left, hold_cnt, idle_cycles;
	bit     taken, no_idle, hold_req;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic longint rnd_div(input longint n, input longint d);
		longint m, q;
		m = n < 0 ? -n : n;
		q = (m + d / 2) / d;
		return n < 0 ? -q : q;
	endfunction

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	task automatic heading_sincos(input longint h, output longint c, output longint s);
		longint x, y, z, nx;
		bit flip;
		x = GAINQ; y = 0; z = h; flip = 0;
		if (z > HPIQ) begin
			z -= PIQ; flip = 1;
		end else if (z < -HPIQ) begin
			z += PIQ; flip = 1;
		end
		for (int i = 0; i < STEPS && i < 30; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i); y = y + (x >>> i); z -= ARCTAN[i];
			end else begin
				nx = x + (y >>> i); y = y - (x >>> i); z += ARCTAN[i];
			end
			x = nx;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	task automatic integrate_tick(input item_t t);
		longint us, vx, vy, wz, c, s, wx, wy, k, nh;
		pose_t r;
		us = t.us; vx = t.vx; vy = t.vy; wz = t.wz;
		if (us <= gap_min || us > gap_max) return;
		if (t.present) begin
			heading_sincos(ph, c, s);
			wx = (vx * c - vy * s + (64'sd1 <<< 29)) >>> 30;
			wy = (vx * s + vy * c + (64'sd1 <<< 29)) >>> 30;
			px = clamp32(px + rnd_div(wx * us, 1000000));
			py = clamp32(py + rnd_div(wy * us, 1000000));
			nh = ph + rnd_div(wz * us * 512, 125000);
			if (nh > PIQ) begin
				k = (nh - PIQ + TPIQ - 1) / TPIQ; nh -= k * TPIQ;
			end else if (nh < -PIQ) begin
				k = (-PIQ - nh + TPIQ - 1) / TPIQ; nh += k * TPIQ;
			end
			ph = nh;
		end else begin
			vx = 0; vy = 0; wz = 0;
		end
		r.x = px[31:0]; r.y = py[31:0]; r.hd = ph[30:0];
		r.vf = vx[31:0]; r.vs = vy[31:0]; r.wr = wz[31:0];
		r.miss = !t.present;
		pose_q.push_back(r);
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55) return 0;
		if (r < 93) return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	// request side
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			integrate_tick(cur);
			taken = 1;
		end
	end

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			taken = 0;
			sender_gap = 0;
		end else if (!in_valid || taken) begin
			taken = 0;
			if (sender_gap > 0) begin
				sender_gap--;
				in_valid <= 0;
			end else if (tick_q.size() > 0) begin
				cur = tick_q.pop_front();
				elapsed_us <= cur.us;
				sample_present <= cur.present;
				vel_fwd <= cur.vx;
				vel_side <= cur.vy;
				turn_rate <= cur.wz;
				in_valid <= 1;
				sender_gap = pick_gap();
			end else begin
				in_valid <= 0;
			end
		end
	end

	// result side
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 0;
			stall_left = 0;
			hold_cnt = 0;
		end else if (hold_cnt > 0) begin
			hold_cnt--;
			out_ready <= 0;
		end else if (hold_req) begin
			hold_req = 0;
			hold_cnt = 400;
			out_ready <= 0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 0;
		end else begin
			out_ready <= 1;
			if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
		end
	end

	always @(posedge clk) begin
		pose_t w;
		if (arst_n && out_valid && out_ready) begin
			if (pose_q.size() == 0) begin
				report("unexpected result", pos_x, 0);
			end else begin
				w = pose_q.pop_front();
				if (pos_x !== w.x) report("pos_x", pos_x, w.x);
				if (pos_y !== w.y) report("pos_y", pos_y, w.y);
				if (heading !== w.hd) report("heading", heading, w.hd);
				if (out_vel_fwd !== w.vf) report("out_vel_fwd", out_vel_fwd, w.vf);
				if (out_vel_side !== w.vs) report("out_vel_side", out_vel_side, w.vs);
				if (out_turn_rate !== w.wr) report("out_turn_rate", out_turn_rate, w.wr);
				if (sample_missing !== w.miss) report("sample_missing", sample_missing, w.miss);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
		else if (tick_q.size() > 0 || pose_q.size() > 0 || in_valid) idle_cycles++;
		if (idle_cycles >= WD_LIMIT) begin
			$display("planar_odometry_integrator_unit_tb: done, errors");
			$finish;
		end
	end

	task automatic add_tick(input longint us, input bit pr, input longint vx,
		input longint vy, input longint wz);
		item_t t;
		t.us = us[19:0]; t.present = pr;
		t.vx = vx[31:0]; t.vy = vy[31:0]; t.wz = wz[31:0];
		tick_q.push_back(t);
	endtask

	function automatic longint rand_vel();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6) return $signed($urandom_range(0, 2 ** 20)) - 2 ** 19;
		if (r < 8) return $signed($urandom());
		return r == 8 ? 64'sd2147483647 : -64'sd2147483648;
	endfunction

	function automatic longint rand_rate();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7) return $signed($urandom_range(0, 2 ** 22)) - 2 ** 21;
		return $signed($urandom());
	endfunction

	task automatic add_random(input int n);
		longint us;
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (gap_min < gap_max && r < 85)
				us = $urandom_range(gap_min + 1, gap_max);
			else
				us = $urandom_range(0, 20'hFFFFF);
			add_tick(us, r >= 70 && r < 85 ? 1'b0 : 1'b1,
				rand_vel(), rand_vel(), rand_rate());
		end
	endtask

	task automatic drain();
		wait (tick_q.size() == 0 && !in_valid && pose_q.size() == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_gaps(input logic [19:0] lo, input logic [19:0] hi);
		@(negedge clk);
		cfg_we <= 1; cfg_addr <= CFG_MIN_GAP; cfg_wdata <= lo;
		@(negedge clk);
		cfg_addr <= CFG_MAX_GAP; cfg_wdata <= hi;
		@(negedge clk);
		cfg_we <= 0;
		gap_min = lo; gap_max = hi;
	endtask

	initial begin
		errors = 0; idle_cycles = 0; no_idle = 0; hold_req = 0;
		cfg_we = 0; cfg_addr = CFG_MIN_GAP; cfg_wdata = 0;
		in_valid = 0; out_ready = 0;
		elapsed_us = 0; sample_present = 0;
		vel_fwd = 0; vel_side = 0; turn_rate = 0;
		gap_min = 1000; gap_max = 200000;
		px = 0; py = 0; ph = 0;
		arst_n = 0;
		repeat (3) @(posedge clk);
		arst_n = 1;

		// window edges, missing sample, saturation, heading wrap
		add_tick(1000, 1, 65536, 0, 0);
		add_tick(1001, 1, 65536, 65536, 65536);
		add_tick(200000, 1, 0, 65536, 64'sd2147483647);
		add_tick(200001, 1, 65536, 0, 0);
		add_tick(0, 1, 0, 0, 0);
		add_tick(20'hFFFFF, 0, 0, 0, 0);
		add_tick(5000, 0, 12345, -6789, 999);
		add_tick(200000, 1, -64'sd2147483648, 64'sd2147483647, -64'sd2147483648);
		repeat (6) add_tick(200000, 1, 64'sd2147483647, 64'sd2147483647, 1 << 18);
		repeat (12) add_tick(200000, 1, -64'sd2147483648, -64'sd2147483648, -(1 << 19));
		add_tick(100000, 1, 0, 0, 205887);
		add_tick(100000, 1, 0, 0, -205887);
		add_tick(150000, 1, 0, 0, 0);
		add_random(280);
		drain();

		set_gaps(0, 1000000);
		no_idle = 1;
		add_random(60);
		drain();
		no_idle = 0;
		@(posedge clk);
		hold_req = 1;
		add_random(340);
		drain();

		set_gaps(500000, 499999);
		add_random(30);
		drain();

		set_gaps(20, 5000);
		add_random(300);
		drain();

		set_gaps(1000000, 1000000);
		add_random(20);
		drain();

		set_gaps(20'hFFFFF, 0);
		add_random(10);
		drain();

		set_gaps(1000, 200000);
		add_random(360);
		drain();

		if (errors == 0)
			$display("planar_odometry_integrator_unit_tb: done, clean");
		else
			$display("planar_odometry_integrator_unit_tb: done, errors");
		$finish;
	end

endmodule

### planar_odometry_integrator_unit.f
rtl/odi_pkg.sv
rtl/odi_front.sv
rtl/odi_queue.sv
rtl/odi_div.sv
rtl/odi_back.sv
rtl/planar_odometry_integrator_unit.sv
dv/planar_odometry_integrator_unit_tb.sv
